@@ design/crs_pkg.sv @@
// Shared codes, reset constants and control types for the clip rectangle stack.
package crs_pkg;

    // Item kinds
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_CLIP   = 2'd2;
    localparam logic [1:0] KIND_REINIT = 2'd3;

    // Configuration register indexes
    localparam logic CFG_SCREEN_W = 1'b0;
    localparam logic CFG_SCREEN_H = 1'b1;

    // Full-screen size after reset
    localparam int SCREEN_W_RESET = 640;
    localparam int SCREEN_H_RESET = 480;

    // Width of the stack level field
    localparam int LEVEL_W = 5;

    typedef struct packed {
        logic load;    // take the input word
        logic calc;    // compute edges, read the stack
        logic commit;  // update the stack, load the result word
    } crs_cmd_t;

    typedef struct packed {
        logic out_full;
    } crs_status_t;

endpackage

@@ design/crs_ctrl.sv @@
// Sequencer for the clip rectangle stack: input handshake and stage commands.
module crs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               m_ready,
    input  crs_pkg::crs_status_t status,
    output crs_pkg::crs_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       can_commit;
    logic       accept;

    assign can_commit = !status.out_full || m_ready;
    assign s_ready    = (state_reg == ST_IDLE) || ((state_reg == ST_FIN) && can_commit);
    assign accept     = s_valid && s_ready;

    assign cmd.load   = accept;
    assign cmd.calc   = (state_reg == ST_CALC);
    assign cmd.commit = (state_reg == ST_FIN) && can_commit;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // hold while the result word is still waiting
                if (can_commit) begin
                    state_next = accept ? ST_CALC : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_calc_then_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CALC |=> state_reg == ST_FIN)
        else $error("calc stage not followed by finish");

    a_fin_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && !cmd.commit) |=> state_reg == ST_FIN)
        else $error("finish stage dropped a stalled item");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == ST_CALC)
        else $error("accepted word did not start the calc stage");

endmodule

@@ design/crs_datapath.sv @@
// Datapath of the clip rectangle stack: entry memory, top entry, edge math, result word.
module crs_datapath #(
    parameter int STACK_DEPTH = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  crs_pkg::crs_cmd_t              cmd,
    output crs_pkg::crs_status_t           status,
    input  logic [1:0]                     s_kind,
    input  logic signed [COORD_BITS-1:0]   s_rect_x,
    input  logic signed [COORD_BITS-1:0]   s_rect_y,
    input  logic signed [COORD_BITS-1:0]   s_rect_w,
    input  logic signed [COORD_BITS-1:0]   s_rect_h,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [COORD_BITS-2:0]          cfg_data,
    input  logic                           m_ready,
    output logic                           m_valid,
    output logic                           m_visible,
    output logic signed [COORD_BITS-1:0]   m_res_x,
    output logic signed [COORD_BITS-1:0]   m_res_y,
    output logic signed [COORD_BITS:0]     m_res_w,
    output logic signed [COORD_BITS:0]     m_res_h,
    output logic [crs_pkg::LEVEL_W-1:0]    m_stack_level,
    output logic                           m_push_ignored
);

    localparam int EW     = COORD_BITS + 2;
    localparam int SW     = COORD_BITS - 1;
    localparam int CW     = $clog2(STACK_DEPTH + 1);
    localparam int AW     = $clog2(STACK_DEPTH);
    localparam int WORD_W = 2 * COORD_BITS + 2 * SW;
    localparam int LW     = crs_pkg::LEVEL_W;
    localparam logic [SW-1:0] SCR_W_RST = SW'(crs_pkg::SCREEN_W_RESET);
    localparam logic [SW-1:0] SCR_H_RST = SW'(crs_pkg::SCREEN_H_RESET);

    // configuration and base entry
    logic [SW-1:0] screen_w_reg;
    logic [SW-1:0] screen_h_reg;
    logic [SW-1:0] base_w_reg;
    logic [SW-1:0] base_w_next;
    logic [SW-1:0] base_h_reg;
    logic [SW-1:0] base_h_next;

    // top entry and count
    logic signed [COORD_BITS-1:0] top_x_reg;
    logic signed [COORD_BITS-1:0] top_x_next;
    logic signed [COORD_BITS-1:0] top_y_reg;
    logic signed [COORD_BITS-1:0] top_y_next;
    logic [SW-1:0]                top_w_reg;
    logic [SW-1:0]                top_w_next;
    logic [SW-1:0]                top_h_reg;
    logic [SW-1:0]                top_h_next;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;

    // input word
    logic [1:0]                   kind_in_reg;
    logic signed [COORD_BITS-1:0] x_in_reg;
    logic signed [COORD_BITS-1:0] y_in_reg;
    logic signed [COORD_BITS-1:0] w_in_reg;
    logic signed [COORD_BITS-1:0] h_in_reg;

    // calc stage
    logic signed [EW-1:0] ix;
    logic signed [EW-1:0] iy;
    logic signed [EW-1:0] ir;
    logic signed [EW-1:0] ib;
    logic signed [EW-1:0] tx;
    logic signed [EW-1:0] ty;
    logic signed [EW-1:0] tw;
    logic signed [EW-1:0] th;
    logic signed [EW-1:0] tr;
    logic signed [EW-1:0] tb;
    logic [CW-1:0]        cnt_m2;
    logic [AW-1:0]        rd_addr;

    logic [1:0]           kind_c_reg;
    logic signed [EW-1:0] x0_reg;
    logic signed [EW-1:0] y0_reg;
    logic signed [EW-1:0] x1_reg;
    logic signed [EW-1:0] y1_reg;
    logic                 hit_reg;
    logic [WORD_W-1:0]    rdata_reg;

    // finish stage
    logic signed [EW-1:0] dw;
    logic signed [EW-1:0] dh;
    logic signed [EW-1:0] pw;
    logic signed [EW-1:0] ph;
    logic                 full;
    logic                 wr_en;
    logic                 ign;
    logic                 vis;
    logic signed [COORD_BITS-1:0] rx;
    logic signed [COORD_BITS-1:0] ry;
    logic signed [COORD_BITS:0]   rw;
    logic signed [COORD_BITS:0]   rh;
    logic [CW+LW-1:0]     lvl_wide;

    // stack memory; entry 0 lives in the base registers and is never stored
    logic [WORD_W-1:0] mem [STACK_DEPTH];

    // result word
    logic                         m_valid_reg;
    logic                         out_vis_reg;
    logic signed [COORD_BITS-1:0] out_x_reg;
    logic signed [COORD_BITS-1:0] out_y_reg;
    logic signed [COORD_BITS:0]   out_w_reg;
    logic signed [COORD_BITS:0]   out_h_reg;
    logic [LW-1:0]                out_lvl_reg;
    logic                         out_ign_reg;

    assign status.out_full = m_valid_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_w_reg <= SCR_W_RST;
            screen_h_reg <= SCR_H_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                crs_pkg::CFG_SCREEN_W: screen_w_reg <= cfg_data;
                crs_pkg::CFG_SCREEN_H: screen_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_in_reg <= s_kind;
            x_in_reg    <= s_rect_x;
            y_in_reg    <= s_rect_y;
            w_in_reg    <= s_rect_w;
            h_in_reg    <= s_rect_h;
        end
    end

    // edges of the item and the top entry at full precision
    always_comb begin
        ix = EW'(x_in_reg);
        iy = EW'(y_in_reg);
        ir = ix + EW'(w_in_reg);
        ib = iy + EW'(h_in_reg);
        tx = EW'(top_x_reg);
        ty = EW'(top_y_reg);
        tw = EW'(top_w_reg);
        th = EW'(top_h_reg);
        tr = tx + tw;
        tb = ty + th;
        cnt_m2  = count_reg - CW'(2);
        rd_addr = cnt_m2[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            kind_c_reg <= kind_in_reg;
            x0_reg     <= (ix > tx) ? ix : tx;
            y0_reg     <= (iy > ty) ? iy : ty;
            x1_reg     <= (tr < ir) ? tr : ir;
            y1_reg     <= (tb < ib) ? tb : ib;
            hit_reg    <= !((ir <= tx) || (ix >= tr) || (ib <= ty) || (iy >= tb));
            // entry below the top, for a pop
            rdata_reg  <= mem[rd_addr];
        end
    end

    always_comb begin
        dw   = x1_reg - x0_reg;
        dh   = y1_reg - y0_reg;
        pw   = (dw > 0) ? dw : '0;
        ph   = (dh > 0) ? dh : '0;
        full = (count_reg == CW'(STACK_DEPTH));

        top_x_next  = top_x_reg;
        top_y_next  = top_y_reg;
        top_w_next  = top_w_reg;
        top_h_next  = top_h_reg;
        base_w_next = base_w_reg;
        base_h_next = base_h_reg;
        count_next  = count_reg;
        wr_en       = 1'b0;
        ign         = 1'b0;

        unique case (kind_c_reg)
            crs_pkg::KIND_PUSH: begin
                if (full) begin
                    ign = 1'b1;
                end else begin
                    wr_en      = 1'b1;
                    top_x_next = x0_reg[COORD_BITS-1:0];
                    top_y_next = y0_reg[COORD_BITS-1:0];
                    top_w_next = pw[SW-1:0];
                    top_h_next = ph[SW-1:0];
                    count_next = count_reg + CW'(1);
                end
            end
            crs_pkg::KIND_POP: begin
                if (count_reg > CW'(1)) begin
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(2)) begin
                        top_x_next = '0;
                        top_y_next = '0;
                        top_w_next = base_w_reg;
                        top_h_next = base_h_reg;
                    end else begin
                        {top_x_next, top_y_next, top_w_next, top_h_next} = rdata_reg;
                    end
                end
            end
            crs_pkg::KIND_REINIT: begin
                base_w_next = screen_w_reg;
                base_h_next = screen_h_reg;
                top_x_next  = '0;
                top_y_next  = '0;
                top_w_next  = screen_w_reg;
                top_h_next  = screen_h_reg;
                count_next  = CW'(1);
            end
            crs_pkg::KIND_CLIP: begin
            end
            default: begin
            end
        endcase

        if (kind_c_reg == crs_pkg::KIND_CLIP) begin
            vis = hit_reg && (dw > 0) && (dh > 0);
            rx  = hit_reg ? x0_reg[COORD_BITS-1:0] : '0;
            ry  = hit_reg ? y0_reg[COORD_BITS-1:0] : '0;
            rw  = hit_reg ? dw[COORD_BITS:0] : '0;
            rh  = hit_reg ? dh[COORD_BITS:0] : '0;
        end else begin
            vis = 1'b0;
            rx  = top_x_next;
            ry  = top_y_next;
            rw  = (COORD_BITS + 1)'(top_w_next);
            rh  = (COORD_BITS + 1)'(top_h_next);
        end

        lvl_wide = (CW + LW)'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) begin
            mem[count_reg[AW-1:0]] <= {top_x_next, top_y_next, top_w_next, top_h_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_x_reg  <= '0;
            top_y_reg  <= '0;
            top_w_reg  <= SCR_W_RST;
            top_h_reg  <= SCR_H_RST;
            base_w_reg <= SCR_W_RST;
            base_h_reg <= SCR_H_RST;
            count_reg  <= CW'(1);
        end else if (cmd.commit) begin
            top_x_reg  <= top_x_next;
            top_y_reg  <= top_y_next;
            top_w_reg  <= top_w_next;
            top_h_reg  <= top_h_next;
            base_w_reg <= base_w_next;
            base_h_reg <= base_h_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_vis_reg <= vis;
            out_x_reg   <= rx;
            out_y_reg   <= ry;
            out_w_reg   <= rw;
            out_h_reg   <= rh;
            out_lvl_reg <= lvl_wide[LW-1:0];
            out_ign_reg <= ign;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_visible      = out_vis_reg;
    assign m_res_x        = out_x_reg;
    assign m_res_y        = out_y_reg;
    assign m_res_w        = out_w_reg;
    assign m_res_h        = out_h_reg;
    assign m_stack_level  = out_lvl_reg;
    assign m_push_ignored = out_ign_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CW'(1)) && (count_reg <= CW'(STACK_DEPTH)))
        else $error("stack count out of range");

    a_ignored_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_ign_reg) |-> (count_reg == CW'(STACK_DEPTH)))
        else $error("push flagged as ignored on a stack that is not full");

    a_base_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CW'(1)) |-> (top_x_reg == '0 && top_y_reg == '0 &&
            top_w_reg == base_w_reg && top_h_reg == base_h_reg))
        else $error("top entry differs from the base entry at level one");

endmodule

@@ design/clip_rectangle_stack.sv @@
// Top level of the clip rectangle stack: sequencer plus datapath.
//
// Input channel s_*: one word per operation (push, pop, clip request, reinit)
// with a rectangle given as x, y, width, height. Result channel m_*: exactly
// one word per input word, in order. For a clip request it carries the clipped
// rectangle and the visible flag; for the other kinds it shows the new top
// entry. stack_level and push_ignored accompany every word.
// Configuration port cfg_*: screen width (index 0) and height (index 1); they
// are picked up at the next reinit. cfg_ready is always high.
// The input word is registered; the calc stage does the edge compares and the
// stack memory read, and the finish stage does the widths and the stack update
// and loads the result word. A new word is taken in the same cycle as the
// previous word commits, so words overlap in that two-stage path.
// Reset leaves one full-screen entry (640 x 480) on the stack and no result
// pending. When the receiver stalls, the pending result holds and the word
// behind it waits in the finish stage; s_ready stays low until it can move.
module clip_rectangle_stack #(
    parameter int STACK_DEPTH = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_kind,
    input  logic signed [COORD_BITS-1:0]   s_rect_x,
    input  logic signed [COORD_BITS-1:0]   s_rect_y,
    input  logic signed [COORD_BITS-1:0]   s_rect_w,
    input  logic signed [COORD_BITS-1:0]   s_rect_h,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_visible,
    output logic signed [COORD_BITS-1:0]   m_res_x,
    output logic signed [COORD_BITS-1:0]   m_res_y,
    output logic signed [COORD_BITS:0]     m_res_w,
    output logic signed [COORD_BITS:0]     m_res_h,
    output logic [crs_pkg::LEVEL_W-1:0]    m_stack_level,
    output logic                           m_push_ignored,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [COORD_BITS-2:0]          cfg_data
);

    crs_pkg::crs_cmd_t    cmd;
    crs_pkg::crs_status_t status;
    logic                 cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    crs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    crs_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_kind         (s_kind),
        .s_rect_x       (s_rect_x),
        .s_rect_y       (s_rect_y),
        .s_rect_w       (s_rect_w),
        .s_rect_h       (s_rect_h),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_visible      (m_visible),
        .m_res_x        (m_res_x),
        .m_res_y        (m_res_y),
        .m_res_w        (m_res_w),
        .m_res_h        (m_res_h),
        .m_stack_level  (m_stack_level),
        .m_push_ignored (m_push_ignored)
    );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the clip rectangle stack: drives words, predicts and checks results.
module tb_top;

    localparam int STACK_DEPTH = 16;
    localparam int COORD_BITS  = 16;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0]         kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } rect_op_t;

    typedef struct {
        logic               visible;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [16:0] w;
        logic signed [16:0] h;
        logic [4:0]         level;
        logic               ignored;
    } clip_result_t;

    typedef struct {
        longint x;
        longint y;
        longint w;
        longint h;
    } box_t;

    typedef struct {
        logic        index;
        logic [14:0] data;
    } cfg_write_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                        s_valid  = 1'b0;
    logic                        s_ready;
    logic [1:0]                  s_kind   = crs_pkg::KIND_CLIP;
    logic signed [15:0]          s_rect_x = '0;
    logic signed [15:0]          s_rect_y = '0;
    logic signed [15:0]          s_rect_w = '0;
    logic signed [15:0]          s_rect_h = '0;
    logic                        m_valid;
    logic                        m_ready  = 1'b0;
    logic                        m_visible;
    logic signed [15:0]          m_res_x;
    logic signed [15:0]          m_res_y;
    logic signed [16:0]          m_res_w;
    logic signed [16:0]          m_res_h;
    logic [crs_pkg::LEVEL_W-1:0] m_stack_level;
    logic                        m_push_ignored;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic                        cfg_index = crs_pkg::CFG_SCREEN_W;
    logic [14:0]                 cfg_data  = '0;

    // Predictor state
    box_t        clip_stack [STACK_DEPTH];
    int unsigned clip_depth;
    logic [14:0] screen_w;
    logic [14:0] screen_h;

    rect_op_t     pending_ops [$];
    rect_op_t     offered_op;
    clip_result_t expected_results [$];
    cfg_write_t   reg_writes [$];

    int errors         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    clip_rectangle_stack #(
        .STACK_DEPTH(STACK_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_rect_x      (s_rect_x),
        .s_rect_y      (s_rect_y),
        .s_rect_w      (s_rect_w),
        .s_rect_h      (s_rect_h),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_visible     (m_visible),
        .m_res_x       (m_res_x),
        .m_res_y       (m_res_y),
        .m_res_w       (m_res_w),
        .m_res_h       (m_res_h),
        .m_stack_level (m_stack_level),
        .m_push_ignored(m_push_ignored),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic void load_full_screen();
        clip_stack[0].x = 0;
        clip_stack[0].y = 0;
        clip_stack[0].w = longint'(screen_w);
        clip_stack[0].h = longint'(screen_h);
        clip_depth = 1;
    endfunction

    // Apply one word to the shadow stack and return the word the block should send back.
    function automatic clip_result_t apply_clip_op(rect_op_t op);
        clip_result_t r;
        box_t         top;
        box_t         nb;
        longint       x, y, w, h, x1, y1, cx1, cy1;
        longint       rx, ry, rw, rh;
        logic         vis;
        logic         ign;
        x   = longint'(op.x);
        y   = longint'(op.y);
        w   = longint'(op.w);
        h   = longint'(op.h);
        vis = 1'b0;
        ign = 1'b0;
        top = clip_stack[4'(clip_depth - 1)];
        case (op.kind)
            crs_pkg::KIND_PUSH: begin
                if (clip_depth >= STACK_DEPTH) begin
                    ign = 1'b1;
                end else begin
                    nb.x = (x > top.x) ? x : top.x;
                    nb.y = (y > top.y) ? y : top.y;
                    x1   = (top.x + top.w < x + w) ? top.x + top.w : x + w;
                    y1   = (top.y + top.h < y + h) ? top.y + top.h : y + h;
                    nb.w = (x1 > nb.x) ? x1 - nb.x : 0;
                    nb.h = (y1 > nb.y) ? y1 - nb.y : 0;
                    clip_stack[4'(clip_depth)] = nb;
                    clip_depth++;
                end
            end
            crs_pkg::KIND_POP: begin
                if (clip_depth > 1) clip_depth--;
            end
            crs_pkg::KIND_REINIT: begin
                load_full_screen();
            end
            default: ;
        endcase

        if (op.kind == crs_pkg::KIND_CLIP) begin
            cx1 = top.x + top.w;
            cy1 = top.y + top.h;
            if (x + w <= top.x || x >= cx1 || y + h <= top.y || y >= cy1) begin
                rx = 0;
                ry = 0;
                rw = 0;
                rh = 0;
            end else begin
                rx  = (x > top.x) ? x : top.x;
                ry  = (y > top.y) ? y : top.y;
                rw  = ((cx1 < x + w) ? cx1 : x + w) - rx;
                rh  = ((cy1 < y + h) ? cy1 : y + h) - ry;
                vis = (rw > 0 && rh > 0);
            end
        end else begin
            top = clip_stack[4'(clip_depth - 1)];
            rx  = top.x;
            ry  = top.y;
            rw  = top.w;
            rh  = top.h;
        end

        r.visible = vis;
        r.x       = rx[15:0];
        r.y       = ry[15:0];
        r.w       = rw[16:0];
        r.h       = rh[16:0];
        r.level   = clip_depth[4:0];
        r.ignored = ign;
        return r;
    endfunction

    task automatic check_field(string name, logic [16:0] exp_v, logic [16:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Input side: hold each word until taken, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(apply_clip_op(offered_op));
            if (!s_valid || s_ready) begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_op = pending_ops.pop_front();
                    s_valid  <= 1'b1;
                    s_kind   <= offered_op.kind;
                    s_rect_x <= offered_op.x;
                    s_rect_y <= offered_op.y;
                    s_rect_w <= offered_op.w;
                    s_rect_h <= offered_op.h;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: check each word, stall at random, hold off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result word with nothing expected", $time);
                end else begin
                    clip_result_t e;
                    e = expected_results.pop_front();
                    check_field("visible", 17'(e.visible), 17'(m_visible));
                    check_field("res_x", 17'(e.x), 17'(m_res_x));
                    check_field("res_y", 17'(e.y), 17'(m_res_y));
                    check_field("res_w", e.w, m_res_w);
                    check_field("res_h", e.h, m_res_h);
                    check_field("stack_level", 17'(e.level), 17'(m_stack_level));
                    check_field("push_ignored", 17'(e.ignored), 17'(m_push_ignored));
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Register writes: the shadow copy follows each accepted write
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == crs_pkg::CFG_SCREEN_W)
                    screen_w = cfg_data;
                else
                    screen_h = cfg_data;
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_writes.size() > 0) begin
                    cfg_write_t wr;
                    wr = reg_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= wr.index;
                    cfg_data  <= wr.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    task automatic add_op(logic [1:0] kind, int x, int y, int w, int h);
        rect_op_t op;
        op.kind = kind;
        op.x    = 16'(x);
        op.y    = 16'(y);
        op.w    = 16'(w);
        op.h    = 16'(h);
        pending_ops.push_back(op);
    endtask

    function automatic rect_op_t make_rect(logic [1:0] kind, bit wild);
        rect_op_t op;
        int       span;
        op.kind = kind;
        if (wild) begin
            op.x = 16'($urandom);
            op.y = 16'($urandom);
            op.w = 16'($urandom);
            op.h = 16'($urandom);
        end else begin
            span = ($urandom_range(3) == 0) ? 40000 : 1000;
            op.x = 16'($urandom_range(span) - span / 8);
            op.y = 16'($urandom_range(span) - span / 8);
            op.w = 16'($urandom_range(span / 2));
            op.h = 16'($urandom_range(span / 2));
            if ($urandom_range(9) == 0) op.w = -op.w;
            if ($urandom_range(9) == 0) op.h = -op.h;
        end
        return op;
    endfunction

    // Bursts of push-heavy, pop-heavy, mixed and noise words
    task automatic queue_random(int count);
        int         made;
        int         burst;
        int         len;
        int         roll;
        logic [1:0] kind;
        bit         wild;
        made = 0;
        while (made < count) begin
            burst = $urandom_range(9);
            len   = $urandom_range(4, 24);
            for (int i = 0; i < len; i++) begin
                roll = $urandom_range(99);
                wild = ($urandom_range(9) == 0);
                case (burst)
                    0, 1: kind = (roll < 80) ? crs_pkg::KIND_PUSH : crs_pkg::KIND_CLIP;
                    2, 3: kind = (roll < 60) ? crs_pkg::KIND_POP : crs_pkg::KIND_CLIP;
                    9: begin
                        kind = 2'($urandom_range(3));
                        wild = 1'b1;
                    end
                    default: begin
                        if (roll < 30)      kind = crs_pkg::KIND_PUSH;
                        else if (roll < 55) kind = crs_pkg::KIND_POP;
                        else if (roll < 95) kind = crs_pkg::KIND_CLIP;
                        else                kind = crs_pkg::KIND_REINIT;
                    end
                endcase
                pending_ops.push_back(make_rect(kind, wild));
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_ops.size() > 0 || s_valid || expected_results.size() > 0 ||
               reg_writes.size() > 0 || cfg_valid);
    endtask

    initial begin
        int         scr_w_tab [6]  = '{32767, 1, 0, -1, 640, 32767};
        int         scr_h_tab [6]  = '{32767, 1, 200, -1, -1, 1};
        int         send_tab [6]   = '{0, 72, 0, 24, 0, 24};
        int         recv_tab [6]   = '{0, 0, 72, 24, 0, 24};
        bit         hold_tab [6]   = '{0, 0, 0, 0, 1, 1};
        cfg_write_t wr;

        screen_w = 15'(crs_pkg::SCREEN_W_RESET);
        screen_h = 15'(crs_pkg::SCREEN_H_RESET);
        load_full_screen();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words against the 640 x 480 base entry
        add_op(crs_pkg::KIND_CLIP, 0, 0, 640, 480);
        add_op(crs_pkg::KIND_CLIP, -32768, -32768, 32767, 32767);
        add_op(crs_pkg::KIND_CLIP, 32767, 32767, 32767, 32767);
        add_op(crs_pkg::KIND_CLIP, 100, 10, -50, 20);      // negative width still overlapping
        add_op(crs_pkg::KIND_CLIP, 10, 100, 20, -50);      // negative height still overlapping
        add_op(crs_pkg::KIND_POP, 0, 0, 0, 0);             // pop with only the base entry left
        add_op(crs_pkg::KIND_PUSH, 100, 50, 200, 100);
        add_op(crs_pkg::KIND_PUSH, -32768, -32768, -1, -1); // empty intersection
        add_op(crs_pkg::KIND_CLIP, 150, 60, 10, 10);       // nothing overlaps an empty top
        add_op(crs_pkg::KIND_REINIT, 0, 0, 0, 0);
        for (int i = 0; i < STACK_DEPTH; i++)
            pending_ops.push_back(make_rect(crs_pkg::KIND_PUSH, 1'b0)); // last one finds it full
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            send_idle_pct  = send_tab[p];
            recv_stall_pct = recv_tab[p];
            wr.index = crs_pkg::CFG_SCREEN_W;
            wr.data  = 15'((scr_w_tab[p] < 0) ? $urandom_range(1, 32767) : scr_w_tab[p]);
            reg_writes.push_back(wr);
            wr.index = crs_pkg::CFG_SCREEN_H;
            wr.data  = 15'((scr_h_tab[p] < 0) ? $urandom_range(1, 32767) : scr_h_tab[p]);
            reg_writes.push_back(wr);
            wait_idle();
            if (hold_tab[p]) hold_req++;
            // Top entry must not change until the reinit
            add_op(crs_pkg::KIND_CLIP, 0, 0, 32767, 32767);
            add_op(crs_pkg::KIND_REINIT, 0, 0, 0, 0);
            add_op(crs_pkg::KIND_CLIP, 0, 0, 32767, 32767);
            queue_random(240);
            wait_idle();
        end

        repeat (10) @(negedge aclk);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #5000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
design/crs_pkg.sv
design/crs_ctrl.sv
design/crs_datapath.sv
design/clip_rectangle_stack.sv
tb/tb_top.sv
